// ===== rtl/core/npd_pkg.sv =====
package npd_pkg;

    // Field widths of one beat.
    localparam int COORD_BITS = 24;
    localparam int TAG_BITS   = 16;
    localparam int OP_BITS    = 2;
    localparam int DIST_BITS  = 25;

    // Stream widths: tdata padded to whole bytes.
    localparam int S_TDATA_W = 88;
    localparam int S_TUSER_W = OP_BITS;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 1;

    // Datapath widths of the distance pipeline.
    localparam int DIFF_W = COORD_BITS + 1;        // signed difference
    localparam int PROD_W = 2 * DIFF_W;            // signed square
    localparam int SQ_W   = 2 * COORD_BITS + 1;    // square magnitude, at most 2^(2*COORD_BITS)
    localparam int SUM_W  = SQ_W + 2;              // sum of three squares
    localparam int ROOT_W = (SUM_W + 1) / 2;       // bits of the integer root

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    // Operation codes on the input tuser.
    localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_BITS-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_QUERY = 2'd2;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
    } point_t;

    typedef struct packed {
        cmd_kind_t           kind;
        point_t              pos;
        logic [TAG_BITS-1:0] tag;
    } cmd_t;

    typedef struct packed {
        logic [DIST_BITS-1:0] distance;
        logic                 empty;
        logic [TAG_BITS-1:0]  tag;
    } res_t;

endpackage

// ===== rtl/core/npd_front.sv =====
module npd_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [npd_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [npd_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                          q_full,
    output logic                          q_push,
    output npd_pkg::cmd_t                 q_cmd
);
    import npd_pkg::*;

    logic op_known;

    assign s_tready = !q_full;

    always_comb begin
        q_cmd.pos.x = s_tdata[COORD_BITS-1:0];
        q_cmd.pos.y = s_tdata[2*COORD_BITS-1:COORD_BITS];
        q_cmd.pos.z = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
        q_cmd.tag   = s_tdata[3*COORD_BITS+TAG_BITS-1:3*COORD_BITS];
        q_cmd.kind  = CMD_CLEAR;
        op_known    = 1'b1;
        unique case (s_tuser)
            OP_CLEAR: q_cmd.kind = CMD_CLEAR;
            OP_LOAD:  q_cmd.kind = CMD_LOAD;
            OP_QUERY: q_cmd.kind = CMD_QUERY;
            default:  op_known = 1'b0;   // unused code: the beat is taken and dropped
        endcase
    end

    assign q_push = s_tvalid && s_tready && op_known;

endmodule

// ===== rtl/core/npd_cmd_queue.sv =====
module npd_cmd_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  npd_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          pop_valid,
    output npd_pkg::cmd_t pop_cmd
);
    import npd_pkg::*;

    cmd_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QFILL_W-1:0] fill_reg, fill_next;

    assign full      = (fill_reg == QFILL_W'(QUEUE_DEPTH));
    assign pop_valid = (fill_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    // The depth is a power of two, so the pointers wrap on their own.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + QFILL_W'(push) - QFILL_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/npd_isqrt.sv =====
module npd_isqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [2*npd_pkg::ROOT_W-1:0]  radicand,
    output logic                          done,
    output logic [npd_pkg::ROOT_W-1:0]    root
);
    import npd_pkg::*;

    localparam int STEP_W = $clog2(ROOT_W);

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [2*ROOT_W-1:0] rad_reg;
    logic [ROOT_W+1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [ROOT_W+1:0]   rem_shift;
    logic [ROOT_W+1:0]   trial;

    // One root bit per step: bring down two radicand bits, try to subtract 4*root+1.
    always_comb begin
        rem_shift = {rem_reg[ROOT_W-1:0], rad_reg[2*ROOT_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        if (rem_shift >= trial) begin
            rem_next  = rem_shift - trial;
            root_next = {root_reg[ROOT_W-2:0], 1'b1};
        end else begin
            rem_next  = rem_shift;
            root_next = {root_reg[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(ROOT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[2*ROOT_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== rtl/core/npd_back.sv =====
module npd_back #(
    parameter int MAX_POINTS = 1024
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    input  npd_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          res_valid,
    output npd_pkg::res_t res,
    input  logic          res_ready
);
    import npd_pkg::*;

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_ROOT  = 5'b01000,
        ST_EMIT  = 5'b10000
    } back_state_t;

    back_state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;

    logic wr_en, rd_en, take_query, isq_start, isq_done;
    logic [ROOT_W-1:0] isq_root;

    point_t mem [MAX_POINTS];
    point_t rd_reg;
    point_t qpos_reg;
    logic [TAG_BITS-1:0] tag_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [PROD_W-1:0] px, py, pz;
    logic [SQ_W-1:0]  sqx_reg, sqy_reg, sqz_reg;
    logic [SUM_W-1:0] sum_reg, best_reg;
    logic [DIST_BITS-1:0] dist_reg;
    logic                 empty_reg;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        q_pop      = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        take_query = 1'b0;
        isq_start  = 1'b0;
        res_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    unique case (q_cmd.kind)
                        CMD_CLEAR: count_next = '0;
                        CMD_LOAD: begin
                            // A load into a full store is dropped.
                            if (count_reg < CNT_W'(MAX_POINTS)) begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_QUERY: begin
                            take_query = 1'b1;
                            idx_next   = '0;
                            state_next = (count_reg == '0) ? ST_EMIT : ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                rd_en    = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == count_reg - 1'b1) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!(v1_reg || v2_reg || v3_reg || v4_reg)) begin
                    isq_start  = 1'b1;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (isq_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            v1_reg    <= rd_en;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
        end
    end

    // Point store: one write port for loads, one registered read port for the scan.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[ADDR_W-1:0]] <= q_cmd.pos;
        end
        if (rd_en) begin
            rd_reg <= mem[idx_reg[ADDR_W-1:0]];
        end
    end

    assign px = dx_reg * dx_reg;
    assign py = dy_reg * dy_reg;
    assign pz = dz_reg * dz_reg;

    // Distance pipeline: difference, square, sum, running minimum.
    always_ff @(posedge aclk) begin
        if (take_query) begin
            qpos_reg <= q_cmd.pos;
            tag_reg  <= q_cmd.tag;
        end
        dx_reg  <= {rd_reg.x[COORD_BITS-1], rd_reg.x} - {qpos_reg.x[COORD_BITS-1], qpos_reg.x};
        dy_reg  <= {rd_reg.y[COORD_BITS-1], rd_reg.y} - {qpos_reg.y[COORD_BITS-1], qpos_reg.y};
        dz_reg  <= {rd_reg.z[COORD_BITS-1], rd_reg.z} - {qpos_reg.z[COORD_BITS-1], qpos_reg.z};
        sqx_reg <= px[SQ_W-1:0];
        sqy_reg <= py[SQ_W-1:0];
        sqz_reg <= pz[SQ_W-1:0];
        sum_reg <= {2'b00, sqx_reg} + {2'b00, sqy_reg} + {2'b00, sqz_reg};
        if (take_query) begin
            best_reg <= '1;
        end else if (v4_reg && (sum_reg < best_reg)) begin
            best_reg <= sum_reg;
        end
        if (take_query) begin
            dist_reg  <= '1;
            empty_reg <= 1'b1;
        end else if (isq_done) begin
            dist_reg  <= (|isq_root[ROOT_W-1:DIST_BITS]) ? '1 : isq_root[DIST_BITS-1:0];
            empty_reg <= 1'b0;
        end
    end

    npd_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (isq_start),
        .radicand ({{(2*ROOT_W-SUM_W){1'b0}}, best_reg}),
        .done     (isq_done),
        .root     (isq_root)
    );

    assign res.distance = dist_reg;
    assign res.empty    = empty_reg;
    assign res.tag      = tag_reg;

endmodule

// ===== rtl/core/nearest_point_distance_core.sv =====
// A query holds the back end while it scans the N stored points through the single read
// port of the point store (one point per cycle) and runs the 26-step bit-serial square
// root; a query on an empty set skips both. The back end takes no new command until it
// has handed on the result. Load and clear beats retire at one per cycle while the back
// end is idle; the input queue absorbs two beats.
// Reset (aresetn low at a clock edge) empties the point set and all queues at once; the
// point store itself is not cleared, since no entry is read before it has been loaded.
module nearest_point_distance_core #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input channel.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata, lowest bit up: pos_x[23:0], pos_y[47:24], pos_z[71:48], query_tag[87:72].
    input  logic [npd_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: operation[1:0] (0 clear, 1 load, 2 query).
    input  logic [npd_pkg::S_TUSER_W-1:0] s_tuser,
    // Result channel.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata, lowest bit up: min_distance[24:0], result_tag[40:25], zero fill [47:41].
    output logic [npd_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: set_empty[0].
    output logic [npd_pkg::M_TUSER_W-1:0] m_tuser
);
    import npd_pkg::*;

    // Front end: takes beats, decodes the operation and drops unused codes.
    logic q_push, q_full, q_valid, q_pop;
    cmd_t push_cmd, pop_cmd;

    npd_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    // The short command queue lets the front keep taking beats while a query scans.
    npd_cmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_cmd   (pop_cmd)
    );

    // Back end: point store, distance pipeline, minimum search and square root.
    logic res_valid, res_ready;
    res_t res;

    npd_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_cmd     (pop_cmd),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    // The output register holds one finished result so the back end can move on to the
    // next command while the consumer stalls.
    logic m_tvalid_reg, m_tvalid_next;
    res_t out_reg;

    assign res_ready     = !m_tvalid_reg || m_tready;
    assign m_tvalid_next = res_valid || (m_tvalid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-DIST_BITS-TAG_BITS){1'b0}}, out_reg.tag, out_reg.distance};
    assign m_tuser  = out_reg.empty;

    // The front never writes into a full queue.
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("command pushed into a full queue");

    // An answer for an empty set always carries the saturated distance.
    a_empty_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.empty) |-> (res.distance == {DIST_BITS{1'b1}}))
        else $error("empty-set result without saturated distance");

    // A result handed to the output register shows up on the port in the next cycle.
    a_result_reaches_port: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready) |=> m_tvalid)
        else $error("accepted result missing from output register");

endmodule
